### rtl/mete_pkg.sv
package mete_pkg;

	// event kinds
	localparam logic [2:0] OP_MIDI       = 3'd0;
	localparam logic [2:0] OP_TEMPO      = 3'd1;
	localparam logic [2:0] OP_LOOP_START = 3'd2;
	localparam logic [2:0] OP_LOOP_END   = 3'd3;
	localparam logic [2:0] OP_TRACK_END  = 3'd4;

	// error codes
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_TICK_BACK  = 3'd1;
	localparam logic [2:0] ERR_STATUS     = 3'd2;
	localparam logic [2:0] ERR_TEMPO_BIG  = 3'd3;
	localparam logic [2:0] ERR_LOOP_START = 3'd4;
	localparam logic [2:0] ERR_LOOP_END   = 3'd5;
	localparam logic [2:0] ERR_BAD_OP     = 3'd6;

	// status high nibbles
	localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
	localparam logic [3:0] KIND_PROGRAM  = 4'hC;
	localparam logic [3:0] KIND_PRESSURE = 4'hD;

	// meta event bytes
	localparam logic [7:0] META_PREFIX     = 8'hff;
	localparam logic [7:0] META_TEMPO      = 8'h51;
	localparam logic [7:0] META_LOOP_START = 8'h2e;
	localparam logic [7:0] META_LOOP_END   = 8'h2d;
	localparam logic [7:0] META_TRACK_END  = 8'h2f;
	localparam logic [7:0] LOOP_COUNT_INF  = 8'hff;

	localparam int LOOP_NEST_DEPTH_DEF = 16;
	localparam int POS_W = 32;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] tick;
		logic [7:0]  status;
		logic [7:0]  data_one;
		logic [7:0]  data_two;
		logic [31:0] note_length;
		logic [31:0] tempo_micros;
		logic [31:0] repeat_count;
	} evt_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
		logic [2:0] error_code;
	} trk_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic        sub;
	} alu_req_t;

	typedef struct packed {
		logic [31:0] sum;
		logic        carry;
	} alu_rsp_t;

	typedef struct packed {
		evt_t        req;
		logic [31:0] delta;
		logic [31:0] offset;
		logic [3:0]  idx;
	} fmt_in_t;

	// number of 7-bit groups in a variable-length number
	function automatic logic [2:0] vl_len(input logic [31:0] v);
		logic [2:0] n;
		if (v[31:28] != 4'd0)      n = 3'd5;
		else if (v[27:21] != 7'd0) n = 3'd4;
		else if (v[20:14] != 7'd0) n = 3'd3;
		else if (v[13:7] != 7'd0)  n = 3'd2;
		else                       n = 3'd1;
		return n;
	endfunction

	// group g of a variable-length number, continuation bit on all but group 0
	function automatic logic [7:0] vl_byte(input logic [31:0] v, input logic [2:0] g);
		logic [6:0] grp;
		unique case (g)
			3'd0:    grp = v[6:0];
			3'd1:    grp = v[13:7];
			3'd2:    grp = v[20:14];
			3'd3:    grp = v[27:21];
			3'd4:    grp = {3'd0, v[31:28]};
			default: grp = 7'd0;
		endcase
		return {(g != 3'd0), grp};
	endfunction

endpackage

### rtl/midi_event_track_encoder.sv
// Serializes one sequence event per request into MIDI track bytes: the tick
// delta as a variable-length number, then the event body (MIDI message,
// tempo, loop start, loop end or track end), one byte per output request with
// last_byte on the final one. A rejected event gives a single byte of zero
// with last_byte set and its error_code, and leaves all state alone. The
// block takes one event at a time and holds evt_stall high until the event
// has been fully written out. Steps per event: take the request, do the tick
// subtract and checks, then the anchor for loop start, or the anchor and
// the back offset for loop end (both go through the same 32-bit adder, stack
// read from RAM), then the output bytes (3 to 13), one per cycle while the
// output does not stall, and a closing step that advances the write position
// through the adder; a rejected event only writes its error byte and has no
// closing step. The loop stack is a RAM of LOOP_NEST_DEPTH 32-bit entries
// with no clearing; only pushed entries are ever popped.
module midi_event_track_encoder #(
	parameter int LOOP_NEST_DEPTH = mete_pkg::LOOP_NEST_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           evt_valid,
	output logic           evt_stall,
	input  mete_pkg::evt_t evt,
	output logic           trk_valid,
	input  logic           trk_stall,
	output mete_pkg::trk_t trk
);

	localparam int AW = (LOOP_NEST_DEPTH > 1) ? $clog2(LOOP_NEST_DEPTH) : 1;
	localparam int DW = $clog2(LOOP_NEST_DEPTH + 1);
	localparam logic [DW-1:0] DEPTH_FULL = DW'(LOOP_NEST_DEPTH);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_SUB  = 7'b0000010,   // tick - previous tick, checks
		ST_POS  = 7'b0000100,   // loop anchor / offset base
		ST_OFF  = 7'b0001000,   // base - popped anchor
		ST_EMIT = 7'b0010000,   // one byte per free output slot
		ST_ERR  = 7'b0100000,   // single error byte
		ST_WPUP = 7'b1000000    // commit position, tick, depth
	} state_t;

	state_t             state_q;
	mete_pkg::evt_t     req_q;
	logic [31:0]        delta_q;
	logic [31:0]        pos_q;
	logic [31:0]        wp_q;
	logic [31:0]        prev_q;
	logic [DW-1:0]      depth_q;
	logic [2:0]         err_q;
	logic [3:0]         idx_q;
	mete_pkg::trk_t     out_q;
	logic               out_vld_q;

	mete_pkg::alu_req_t alu_rq;
	mete_pkg::alu_rsp_t alu_rs;
	mete_pkg::fmt_in_t  fmt_in;
	logic [7:0]         fmt_byte;
	logic [3:0]         total;
	logic [2:0]         dlen;
	logic [2:0]         err_code;
	logic               slot_free;
	logic               out_fire;
	logic               is_last;
	logic               ram_we;
	logic               ram_re;
	logic [AW-1:0]      ram_waddr;
	logic [AW-1:0]      ram_raddr;
	logic [DW-1:0]      depth_dec;
	logic [31:0]        anchor;

	assign evt_stall = (state_q != ST_IDLE);
	assign trk_valid = out_vld_q;
	assign trk       = out_q;
	assign slot_free = !out_vld_q || !trk_stall;
	// a byte (data or error) goes into the output register this cycle
	assign out_fire  = ((state_q == ST_EMIT) || (state_q == ST_ERR)) && slot_free;

	assign dlen      = mete_pkg::vl_len(delta_q);
	assign depth_dec = depth_q - DW'(1);
	assign is_last   = (idx_q == total - 4'd1);

	// shared adder: one operation per sequencer step
	always_comb begin
		alu_rq = '{a: 32'd0, b: 32'd0, sub: 1'b0};
		unique case (state_q)
			ST_SUB: alu_rq = '{a: req_q.tick, b: prev_q, sub: 1'b1};
			ST_POS: begin
				// loop start anchors at the last delta byte, loop end needs pos + 8
				if (req_q.op == mete_pkg::OP_LOOP_START) begin
					alu_rq = '{a: wp_q, b: {29'd0, dlen - 3'd1}, sub: 1'b0};
				end else begin
					alu_rq = '{a: wp_q, b: {28'd0, {1'b0, dlen} + 4'd8}, sub: 1'b0};
				end
			end
			ST_OFF:  alu_rq = '{a: pos_q, b: anchor, sub: 1'b1};
			ST_WPUP: alu_rq = '{a: wp_q, b: {28'd0, total}, sub: 1'b0};
			default: alu_rq = '{a: 32'd0, b: 32'd0, sub: 1'b0};
		endcase
	end

	mete_alu u_alu (
		.rq (alu_rq),
		.rs (alu_rs)
	);

	assign fmt_in = '{req: req_q, delta: delta_q, offset: pos_q, idx: idx_q};

	mete_fmt u_fmt (
		.fi    (fmt_in),
		.data  (fmt_byte),
		.total (total)
	);

	// backwards tick first, then the check of the event kind
	always_comb begin
		err_code = mete_pkg::ERR_NONE;
		if (!alu_rs.carry) begin
			err_code = mete_pkg::ERR_TICK_BACK;
		end else begin
			unique case (req_q.op)
				mete_pkg::OP_MIDI: begin
					if (!req_q.status[7]) err_code = mete_pkg::ERR_STATUS;
				end
				mete_pkg::OP_TEMPO: begin
					if (req_q.tempo_micros[31:24] != 8'd0) err_code = mete_pkg::ERR_TEMPO_BIG;
				end
				mete_pkg::OP_LOOP_START: begin
					if (depth_q == DEPTH_FULL || req_q.repeat_count[31:16] != 16'd0) begin
						err_code = mete_pkg::ERR_LOOP_START;
					end
				end
				mete_pkg::OP_LOOP_END: begin
					// a zero count means 255 and always fits
					if (depth_q == DW'(0) || req_q.repeat_count[31:8] != 24'd0) begin
						err_code = mete_pkg::ERR_LOOP_END;
					end
				end
				mete_pkg::OP_TRACK_END: err_code = mete_pkg::ERR_NONE;
				default:                err_code = mete_pkg::ERR_BAD_OP;
			endcase
		end
	end

	// loop stack: push while computing the anchor, pop read during the checks
	assign ram_we    = (state_q == ST_POS) && (req_q.op == mete_pkg::OP_LOOP_START);
	assign ram_waddr = depth_q[AW-1:0];
	assign ram_re    = (state_q == ST_SUB) && (req_q.op == mete_pkg::OP_LOOP_END);
	assign ram_raddr = depth_dec[AW-1:0];

	mete_ram #(
		.WIDTH (mete_pkg::POS_W),
		.DEPTH (LOOP_NEST_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (alu_rs.sum),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (anchor)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wp_q      <= 32'd0;
			prev_q    <= 32'd0;
			depth_q   <= '0;
			idx_q     <= 4'd0;
			out_vld_q <= 1'b0;
		end else begin
			// new byte loaded, or the held one still waiting
			out_vld_q <= out_fire || (out_vld_q && trk_stall);
			unique case (state_q)
				ST_IDLE: begin
					if (evt_valid) begin
						state_q <= ST_SUB;
						idx_q   <= 4'd0;
					end
				end
				ST_SUB: begin
					if (err_code != mete_pkg::ERR_NONE) begin
						state_q <= ST_ERR;
					end else if (req_q.op == mete_pkg::OP_LOOP_START
					             || req_q.op == mete_pkg::OP_LOOP_END) begin
						state_q <= ST_POS;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_POS: begin
					state_q <= (req_q.op == mete_pkg::OP_LOOP_END) ? ST_OFF : ST_EMIT;
				end
				ST_OFF: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (slot_free) begin
						idx_q <= idx_q + 4'd1;
						if (is_last) begin
							state_q <= ST_WPUP;
						end
					end
				end
				ST_ERR: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_WPUP: begin
					wp_q    <= alu_rs.sum;
					prev_q  <= req_q.tick;
					if (req_q.op == mete_pkg::OP_LOOP_START) begin
						depth_q <= depth_q + DW'(1);
					end else if (req_q.op == mete_pkg::OP_LOOP_END) begin
						depth_q <= depth_dec;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && evt_valid) begin
			req_q <= evt;
		end
		if (state_q == ST_SUB) begin
			delta_q <= alu_rs.sum;
			err_q   <= err_code;
		end
		if (state_q == ST_POS || state_q == ST_OFF) begin
			pos_q <= alu_rs.sum;
		end
		if (state_q == ST_EMIT && slot_free) begin
			out_q <= '{out_byte: fmt_byte, last_byte: is_last, error_code: mete_pkg::ERR_NONE};
		end
		if (state_q == ST_ERR && slot_free) begin
			out_q <= '{out_byte: 8'h00, last_byte: 1'b1, error_code: err_q};
		end
	end

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_FULL)
		else $error("loop depth beyond stack size");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> depth_q != DEPTH_FULL)
		else $error("push into full loop stack");

	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_q.error_code != mete_pkg::ERR_NONE
		|-> out_q.last_byte && out_q.out_byte == 8'h00)
		else $error("error result not a single zero byte");

	a_wp_commit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WPUP |=> wp_q == $past(wp_q) + {28'd0, $past(total)})
		else $error("write position not advanced by event length");

endmodule

### rtl/mete_ram.sv
module mete_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/mete_alu.sv
module mete_alu (
	input  mete_pkg::alu_req_t rq,
	output mete_pkg::alu_rsp_t rs
);

	logic [32:0] sum;

	// a + b, or a - b with carry high when no borrow
	assign sum = {1'b0, rq.a} + {1'b0, (rq.sub ? ~rq.b : rq.b)} + {32'd0, rq.sub};
	assign rs.sum   = sum[31:0];
	assign rs.carry = sum[32];

endmodule

### rtl/mete_fmt.sv
module mete_fmt (
	input  mete_pkg::fmt_in_t fi,
	output logic [7:0]        data,
	output logic [3:0]        total
);

	logic [2:0] dlen;
	logic [2:0] nlen;
	logic [3:0] kind;
	logic [3:0] blen;
	logic [3:0] j;
	logic [3:0] g4;
	logic [7:0] cnt;

	assign dlen = mete_pkg::vl_len(fi.delta);
	assign nlen = mete_pkg::vl_len(fi.req.note_length);
	assign kind = fi.req.status[7:4];
	assign cnt  = (fi.req.repeat_count == 32'd0) ? mete_pkg::LOOP_COUNT_INF
	                                             : fi.req.repeat_count[7:0];
	assign j     = fi.idx - {1'b0, dlen};
	assign total = {1'b0, dlen} + blen;

	always_comb begin
		unique case (fi.req.op)
			mete_pkg::OP_MIDI: begin
				if (kind == mete_pkg::KIND_PROGRAM || kind == mete_pkg::KIND_PRESSURE) begin
					blen = 4'd2;
				end else if (kind == mete_pkg::KIND_NOTE_ON) begin
					blen = 4'd3 + {1'b0, nlen};
				end else begin
					blen = 4'd3;
				end
			end
			mete_pkg::OP_TEMPO:      blen = 4'd5;
			mete_pkg::OP_LOOP_START: blen = 4'd4;
			mete_pkg::OP_LOOP_END:   blen = 4'd8;
			mete_pkg::OP_TRACK_END:  blen = 4'd2;
			default:                 blen = 4'd0;
		endcase
	end

	always_comb begin
		data = 8'h00;
		g4   = 4'd0;
		if (fi.idx < {1'b0, dlen}) begin
			g4   = {1'b0, dlen} - 4'd1 - fi.idx;
			data = mete_pkg::vl_byte(fi.delta, g4[2:0]);
		end else begin
			unique case (fi.req.op)
				mete_pkg::OP_MIDI: begin
					unique case (j)
						4'd0:    data = fi.req.status;
						4'd1:    data = fi.req.data_one;
						4'd2:    data = fi.req.data_two;
						default: begin
							// note duration, most significant group first
							g4   = {1'b0, nlen} + 4'd2 - j;
							data = mete_pkg::vl_byte(fi.req.note_length, g4[2:0]);
						end
					endcase
				end
				mete_pkg::OP_TEMPO: begin
					unique case (j)
						4'd0:    data = mete_pkg::META_PREFIX;
						4'd1:    data = mete_pkg::META_TEMPO;
						4'd2:    data = fi.req.tempo_micros[23:16];
						4'd3:    data = fi.req.tempo_micros[15:8];
						default: data = fi.req.tempo_micros[7:0];
					endcase
				end
				mete_pkg::OP_LOOP_START: begin
					unique case (j)
						4'd0:    data = mete_pkg::META_PREFIX;
						4'd1:    data = mete_pkg::META_LOOP_START;
						4'd2:    data = fi.req.repeat_count[15:8];
						default: data = fi.req.repeat_count[7:0];
					endcase
				end
				mete_pkg::OP_LOOP_END: begin
					unique case (j)
						4'd0:    data = mete_pkg::META_PREFIX;
						4'd1:    data = mete_pkg::META_LOOP_END;
						4'd2:    data = cnt;
						4'd3:    data = cnt;
						4'd4:    data = fi.offset[31:24];
						4'd5:    data = fi.offset[23:16];
						4'd6:    data = fi.offset[15:8];
						default: data = fi.offset[7:0];
					endcase
				end
				mete_pkg::OP_TRACK_END: begin
					data = (j == 4'd0) ? mete_pkg::META_PREFIX : mete_pkg::META_TRACK_END;
				end
				default: data = 8'h00;
			endcase
		end
	end

endmodule
